// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_BLANK     = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

   typedef enum logic [2:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_BACKSPACE,
      KIND_READ,
      KIND_CLEAR,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [7:0] attr;
   } cmd_type;

endpackage

// File: hdl/tcw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: one console command item per handshake.
// ----------------------------------------------------------------------------
interface tcw_req_if #(
   parameter int COL_W = 7,
   parameter int ROW_W = 5
);
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [7:0]       ch;
   logic [7:0]       attr;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;

   modport source (output valid, opcode, ch, attr, column, row, input ready);
   modport sink   (input valid, opcode, ch, attr, column, row, output ready);
endinterface

// File: hdl/tcw_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: one result item per command.
// ----------------------------------------------------------------------------
interface tcw_rsp_if #(
   parameter int CELL_W = 11
);
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cursor_pos;
   logic [7:0]        read_char;
   logic [7:0]        read_attr;
   logic              scrolled;

   modport source (output valid, cursor_pos, read_char, read_attr, scrolled, input ready);
   modport sink   (input valid, cursor_pos, read_char, read_attr, scrolled, output ready);
endinterface

// File: hdl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request items, decodes them into commands and works out the
// linear address of a cell read.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   tcw_req_if.sink                         req_if,
   input  logic                            init_done,
   input  logic                            queue_full,
   output logic                            push,
   output cmd_type                         cmd,
   output logic [$clog2(ROWS*COLUMNS)-1:0] cmd_addr
);

   localparam int CELL_W = $clog2(ROWS*COLUMNS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   logic in_range;

   assign req_if.ready = init_done && !queue_full;
   assign push         = req_if.valid && req_if.ready;

   assign in_range = ({1'b0, req_if.column} < (COL_W+1)'(COLUMNS))
                  && ({1'b0, req_if.row} < (ROW_W+1)'(ROWS));

   assign cmd_addr = CELL_W'(CELL_W'(req_if.row) * CELL_W'(COLUMNS)
                           + CELL_W'(req_if.column));

   always_comb begin
      cmd.ch   = req_if.ch;
      cmd.attr = req_if.attr;
      case (req_if.opcode)
         OP_PUT: begin
            if (req_if.ch == CH_NEWLINE) begin
               cmd.kind = KIND_NEWLINE;
            end else if (req_if.ch == CH_BACKSPACE) begin
               cmd.kind = KIND_BACKSPACE;
            end else begin
               cmd.kind = KIND_PUT;
            end
         end
         OP_READ: begin
            cmd.kind = in_range ? KIND_READ : KIND_NOP;
         end
         OP_CLEAR: begin
            cmd.kind = KIND_CLEAR;
         end
         default: begin
            cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule

// File: hdl/tcw_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cmd_fifo
// Short command queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo import tcw_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign dout      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: hdl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen store: cell writes, reads, the
// scroll copy and the fill sweeps, and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  cmd_type                         cmd,
   input  logic [$clog2(ROWS*COLUMNS)-1:0] cmd_addr,
   output logic                            cmd_pop,
   input  logic [7:0]                      fill_attr,
   output logic                            init_done,
   tcw_rsp_if.source                       rsp_if
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int LAST_ROW  = (ROWS - 1) * COLUMNS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_COPY = 4'b0100,
      ST_FILL = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0] lin_ff, lin_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              wpend_ff, wpend_in;
   logic [CELL_W-1:0] waddr_ff, waddr_in;
   logic [15:0]       fill_data_ff, fill_data_in;
   logic              res_pend_ff, res_pend_in;
   logic              res_scr_ff, res_scr_in;
   logic              init_done_ff, init_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cur_ff;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic              rsp_load;
   logic              rsp_free;
   logic              ram_we;
   logic [CELL_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic [CELL_W-1:0] ram_raddr;
   logic [15:0]       ram_rdata;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && rsp_free;
   assign init_done = init_done_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lin_in       = lin_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wpend_in     = 1'b0;
      waddr_in     = waddr_ff;
      fill_data_in = fill_data_ff;
      res_pend_in  = res_pend_ff;
      res_scr_in   = res_scr_ff;
      init_done_in = init_done_ff;
      rsp_load     = 1'b0;
      rsp_char_in  = '0;
      rsp_attr_in  = '0;
      rsp_scr_in   = 1'b0;
      ram_we       = wpend_ff;
      ram_waddr    = waddr_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = cmd_addr;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd.kind)
                  KIND_PUT: begin
                     ram_we    = 1'b1;
                     ram_waddr = lin_ff;
                     ram_wdata = {cmd.attr, cmd.ch};
                     if (lin_ff == CELL_W'(CELLS - 1)) begin
                        lin_in      = CELL_W'(LAST_ROW);
                        col_in      = '0;
                        row_in      = ROW_W'(ROWS - 1);
                        cnt_in      = '0;
                        res_pend_in = 1'b1;
                        res_scr_in  = 1'b1;
                        state_in    = ST_COPY;
                     end else begin
                        lin_in   = lin_ff + 1'b1;
                        rsp_load = 1'b1;
                        if (col_ff == COL_W'(COLUMNS - 1)) begin
                           col_in = '0;
                           row_in = row_ff + 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  end
                  KIND_NEWLINE: begin
                     if (row_ff == ROW_W'(ROWS - 1)) begin
                        lin_in      = CELL_W'(LAST_ROW);
                        col_in      = '0;
                        cnt_in      = '0;
                        res_pend_in = 1'b1;
                        res_scr_in  = 1'b1;
                        state_in    = ST_COPY;
                     end else begin
                        lin_in   = lin_ff + CELL_W'(COLUMNS) - CELL_W'(col_ff);
                        col_in   = '0;
                        row_in   = row_ff + 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  KIND_BACKSPACE: begin
                     rsp_load = 1'b1;
                     if (lin_ff != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = lin_ff - 1'b1;
                        ram_wdata = {cmd.attr, CH_BLANK};
                        lin_in    = lin_ff - 1'b1;
                        if (col_ff == '0) begin
                           col_in = COL_W'(COLUMNS - 1);
                           row_in = row_ff - 1'b1;
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                  end
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  KIND_CLEAR: begin
                     lin_in       = '0;
                     col_in       = '0;
                     row_in       = '0;
                     cnt_in       = '0;
                     fill_data_in = {cmd.attr, CH_BLANK};
                     res_pend_in  = 1'b1;
                     res_scr_in   = 1'b0;
                     state_in     = ST_FILL;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_char_in = ram_rdata[7:0];
            rsp_attr_in = ram_rdata[15:8];
            state_in    = ST_IDLE;
         end
         ST_COPY: begin
            // read one row below, write it to the current cell in the next cycle
            ram_raddr = cnt_ff + CELL_W'(COLUMNS);
            wpend_in  = 1'b1;
            waddr_in  = cnt_ff;
            if (cnt_ff == CELL_W'(LAST_ROW - 1)) begin
               cnt_in       = CELL_W'(LAST_ROW);
               fill_data_in = {fill_attr, CH_BLANK};
               state_in     = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FILL: begin
            if (!wpend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff;
               ram_wdata = fill_data_ff;
               if (cnt_ff == CELL_W'(CELLS - 1)) begin
                  state_in     = ST_IDLE;
                  init_done_in = 1'b1;
                  res_pend_in  = 1'b0;
                  rsp_load     = res_pend_ff;
                  rsp_scr_in   = res_scr_ff;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         lin_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         wpend_ff     <= 1'b0;
         fill_data_ff <= {RESET_ATTR, CH_BLANK};
         res_pend_ff  <= 1'b0;
         res_scr_ff   <= 1'b0;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lin_ff       <= lin_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wpend_ff     <= wpend_in;
         fill_data_ff <= fill_data_in;
         res_pend_ff  <= res_pend_in;
         res_scr_ff   <= res_scr_in;
         init_done_ff <= init_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff <= waddr_in;
      if (rsp_load) begin
         rsp_cur_ff  <= lin_in;
         rsp_char_ff <= rsp_char_in;
         rsp_attr_ff <= rsp_attr_in;
         rsp_scr_ff  <= rsp_scr_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_pos = rsp_cur_ff;
   assign rsp_if.read_char  = rsp_char_ff;
   assign rsp_if.read_attr  = rsp_attr_ff;
   assign rsp_if.scrolled   = rsp_scr_ff;

endmodule

// File: hdl/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with a linear cursor and scrolling.
//
// req_if takes one command item per handshake (put character, read cell,
// clear screen); rsp_if returns exactly one result item per command, in
// order. csr_we/csr_wdata set the attribute of the blank row that a scroll
// adds, and may be written only while the console is idle.
// Items pass a decoder into a two-entry queue; the executor owns the
// single-write, single-read screen RAM. It takes a new command from the
// queue only while idle and its result register is free: a read passes
// through a read state, a clear sweeps every cell, and a scroll copies
// each row up and then sweeps the bottom row to blanks.
// After reset the whole screen is swept to blanks in attribute 0x07, one
// cell a cycle; req_if.ready stays low meanwhile. A stalled rsp_if holds its
// item in the output register while up to two more items queue; then
// req_if.ready drops.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_if,
   tcw_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int QUEUE_W = $bits(cmd_type) + CELL_W;

   logic [7:0]        fill_attr_ff, fill_attr_in;
   logic              init_done;
   logic              queue_full;
   logic              queue_not_empty;
   logic              push;
   logic              pop;
   cmd_type           front_cmd;
   logic [CELL_W-1:0] front_addr;
   logic [QUEUE_W-1:0] queue_dout;
   cmd_type           back_cmd;
   logic [CELL_W-1:0] back_addr;

   assign fill_attr_in = csr_we ? csr_wdata : fill_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_attr_ff <= RESET_ATTR;
      end else begin
         fill_attr_ff <= fill_attr_in;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_if     (req_if),
      .init_done  (init_done),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd),
      .cmd_addr   (front_addr)
   );

   tcw_cmd_fifo #(
      .WIDTH (QUEUE_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       ({front_cmd, front_addr}),
      .pop       (pop),
      .dout      (queue_dout),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   assign back_cmd  = queue_dout[QUEUE_W-1:CELL_W];
   assign back_addr = queue_dout[CELL_W-1:0];

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (back_cmd),
      .cmd_addr  (back_addr),
      .cmd_pop   (pop),
      .fill_attr (fill_attr_ff),
      .init_done (init_done),
      .rsp_if    (rsp_if)
   );

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.cursor_pos < CELL_W'(CELLS - 1) ||
                        rsp_if.cursor_pos == CELL_W'(CELLS - 1)))
      else $error("cursor beyond the screen");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.scrolled) |->
         (rsp_if.cursor_pos == CELL_W'((ROWS - 1) * COLUMNS) &&
          rsp_if.read_char == '0 && rsp_if.read_attr == '0))
      else $error("scroll item with wrong cursor or read data");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty && init_done)
      else $error("command taken from an empty queue or during the sweep");

endmodule

// File: tb/text_console_writer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer.
//
// Sends put, newline, backspace, read, clear and ignored command items with
// random gaps on the request side and random stalls on the result side. A
// shadow screen, cursor and fill attribute predict each result item, which
// is compared field by field, in order, with what the console returns. The
// fill attribute is rewritten between phases while the console is idle.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
   import tcw_pkg::*;

   localparam int         CELL_COUNT   = COLUMNS_DEF * ROWS_DEF;
   localparam int         BOTTOM_ROW   = (ROWS_DEF - 1) * COLUMNS_DEF;
   localparam logic [1:0] OP_IGNORED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 2_000_000;
   localparam int         TAIL_CYCLES  = 50;
   localparam int         RANDOM_ITEMS = 1650;
   localparam int         PHASE_COUNT  = 6;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
      logic        scrolled;
   } console_reply_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   text_console_writer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [15:0]       screen_shadow [CELL_COUNT];
   int unsigned       cursor_shadow;
   logic [7:0]        fill_attr_shadow;
   console_reply_type replies_due [$];
   int unsigned       error_count = 0;
   int unsigned       item_count  = 0;
   bit                req_calm    = 1'b0;
   bit                rsp_calm    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void fill_screen(input logic [7:0] attr);
      for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = {attr, CH_BLANK};
   endfunction

   // scroll when the cursor has run off the end of the screen
   function automatic logic wrap_cursor();
      if (cursor_shadow < CELL_COUNT) return 1'b0;
      for (int i = 0; i < BOTTOM_ROW; i++) screen_shadow[i] = screen_shadow[i + COLUMNS_DEF];
      for (int i = BOTTOM_ROW; i < CELL_COUNT; i++) screen_shadow[i] = {fill_attr_shadow, CH_BLANK};
      cursor_shadow = BOTTOM_ROW;
      return 1'b1;
   endfunction

   function automatic console_reply_type apply_console_cmd(input logic [1:0] op,
                                                           input logic [7:0] ch,
                                                           input logic [7:0] attr,
                                                           input logic [6:0] column,
                                                           input logic [4:0] row);
      console_reply_type res;
      res = '0;
      if (op == OP_PUT) begin
         if (ch == CH_NEWLINE) begin
            cursor_shadow = cursor_shadow + COLUMNS_DEF - cursor_shadow % COLUMNS_DEF;
            res.scrolled  = wrap_cursor();
         end else if (ch == CH_BACKSPACE) begin
            if (cursor_shadow > 0) begin
               cursor_shadow--;
               screen_shadow[cursor_shadow] = {attr, CH_BLANK};
            end
         end else begin
            screen_shadow[cursor_shadow] = {attr, ch};
            cursor_shadow++;
            res.scrolled = wrap_cursor();
         end
      end else if (op == OP_READ) begin
         if (column < COLUMNS_DEF && row < ROWS_DEF) begin
            {res.read_attr, res.read_char} = screen_shadow[row * COLUMNS_DEF + column];
         end
      end else if (op == OP_CLEAR) begin
         fill_screen(attr);
         cursor_shadow = 0;
      end
      res.cursor_pos = cursor_shadow[10:0];
      return res;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] attr,
                           input logic [6:0] column, input logic [4:0] row);
      int unsigned gap;
      gap = pick_gap(req_calm);
      if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.opcode <= op;
      req_if.ch     <= ch;
      req_if.attr   <= attr;
      req_if.column <= column;
      req_if.row    <= row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      replies_due.push_back(apply_console_cmd(op, ch, attr, column, row));
      if (op != OP_IGNORED) item_count++;
   endtask

   task automatic put_char(input logic [7:0] ch, input logic [7:0] attr);
      send_cmd(OP_PUT, ch, attr, 7'($urandom), 5'($urandom));
   endtask

   task automatic read_cell(input logic [6:0] column, input logic [4:0] row);
      send_cmd(OP_READ, 8'($urandom), 8'($urandom), column, row);
   endtask

   task automatic settle(input int unsigned tail);
      req_if.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_fill_attr(input logic [7:0] value);
      settle(4);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      fill_attr_shadow = value;
   endtask

   // backspace with the cursor at home changes nothing
   task automatic test_home_backspace();
      put_char(CH_BACKSPACE, 8'h5A);
      read_cell(7'd0, 5'd0);
   endtask

   task automatic test_field_extremes();
      put_char(8'hFF, 8'hFF);
      put_char(8'h00, 8'h00);
      put_char(CH_BACKSPACE, 8'hC3);
      read_cell(7'd0, 5'd0);
      read_cell(7'd1, 5'd0);
      read_cell(7'(COLUMNS_DEF - 1), 5'(ROWS_DEF - 1));
      read_cell(7'h7F, 5'h1F);
      read_cell(7'(COLUMNS_DEF), 5'd0);
      send_cmd(OP_IGNORED, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
   endtask

   task automatic test_clear_screen();
      send_cmd(OP_CLEAR, 8'h00, 8'hA5, 7'd0, 5'd0);
      read_cell(7'd40, 5'd12);
   endtask

   // newline on the bottom row scrolls in a blank row in the fill attribute
   task automatic test_bottom_scroll();
      set_fill_attr(8'h3C);
      put_char(8'h58, 8'h1F);
      repeat (ROWS_DEF) put_char(CH_NEWLINE, 8'($urandom));
      read_cell(7'd0, 5'(ROWS_DEF - 1));
      read_cell(7'd0, 5'd0);
   endtask

   task automatic test_random_traffic(input int unsigned quota);
      int unsigned target;
      int unsigned len;
      int unsigned pick;
      target = item_count + quota;
      while (item_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 170) : $urandom_range(0, 60);
            repeat (len) begin
               if ($urandom_range(0, 19) == 0) put_char(CH_BACKSPACE, 8'($urandom));
               else put_char(8'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 4) != 0) put_char(CH_NEWLINE, 8'($urandom));
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 5) == 0) read_cell(7'($urandom), 5'($urandom));
               else read_cell(7'($urandom_range(0, COLUMNS_DEF - 1)),
                              5'($urandom_range(0, ROWS_DEF - 1)));
            end
         end else if (pick < 89) begin
            send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
         end else begin
            send_cmd(2'($urandom), 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   initial begin : reply_checker
      console_reply_type want;
      int unsigned       stall;
      rsp_if.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
               error_count++;
               $display("%0t: result item with nothing outstanding, expected none, got cursor_pos %0d",
                        $time, rsp_if.cursor_pos);
            end else begin
               want = replies_due.pop_front();
               check_field("cursor_pos", want.cursor_pos, rsp_if.cursor_pos);
               check_field("read_char", want.read_char, rsp_if.read_char);
               check_field("read_attr", want.read_attr, rsp_if.read_attr);
               check_field("scrolled", want.scrolled, rsp_if.scrolled);
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap(rsp_calm);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = 8'h00;
      req_if.valid  = 1'b0;
      req_if.opcode = OP_PUT;
      req_if.ch     = 8'h00;
      req_if.attr   = 8'h00;
      req_if.column = 7'd0;
      req_if.row    = 5'd0;
      fill_screen(RESET_ATTR);
      cursor_shadow    = 0;
      fill_attr_shadow = RESET_ATTR;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_home_backspace();
      test_field_extremes();
      test_clear_screen();
      test_bottom_scroll();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               set_fill_attr(8'h00);
            end
            1: begin
               set_fill_attr(8'hFF);
            end
            default: begin
               set_fill_attr(8'($urandom));
            end
         endcase
         test_random_traffic(RANDOM_ITEMS / PHASE_COUNT);
      end

      settle(TAIL_CYCLES);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
